/* rtl/core/utf8v_pkg.sv */
`default_nettype none

package utf8v_pkg;

  localparam int MAX_SEQUENCE_DEF = 6;
  localparam int LEN_W            = 3;
  localparam logic [7:0] REPLACE_RESET = 8'h3F;
  localparam logic [1:0] CONT_TAG      = 2'b10;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_bad;
    logic       out_last;
    logic       string_valid;
  } out_t;

  typedef enum logic [2:0] {
    K_EMPTY,
    K_SINGLE,
    K_WAIT,
    K_BAD,
    K_GOOD
  } front_kind_t;

  typedef enum logic [1:0] {
    SEL_FRONT,
    SEL_REPLACE,
    SEL_LATCH
  } emit_sel_t;

  typedef struct packed {
    logic      latch;
    logic      append;
    logic      shift;
    logic      emit;
    emit_sel_t sel;
    logic      bad;
    logic      pass_load_len;
    logic      pass_load_cnt;
    logic      pass_dec;
    logic      set_err;
    logic      set_abort;
    logic      end_str;
    logic      set_term;
  } dp_cmd_t;

  typedef struct packed {
    front_kind_t kind;
    logic        out_free;
    logic        replace_zero;
    logic        last_one;
    logic        pass_one;
    logic        zero_r;
    logic        last_r;
    logic        aborted;
    logic        terminated;
    logic        in_zero_now;
    logic        in_last_now;
  } dp_status_t;

  function automatic logic [LEN_W-1:0] lead_length(input logic [7:0] c,
                                                   input logic [LEN_W-1:0] max_len);
    logic [LEN_W-1:0] len;
    if (!c[7]) len = LEN_W'(1);
    else if (!c[6]) len = LEN_W'(0);
    else if (!c[5]) len = LEN_W'(2);
    else if (!c[4]) len = LEN_W'(3);
    else if (!c[3]) len = LEN_W'(4);
    else if (!c[2]) len = LEN_W'(5);
    else if (!c[1]) len = LEN_W'(6);
    else len = LEN_W'(0);
    if (len > max_len) len = LEN_W'(0);
    return len;
  endfunction

  // value below max(128, 2^(5n-4)): top five payload bits (four for two bytes) are all zero
  function automatic logic overlong(input logic [LEN_W-1:0] len,
                                    input logic [7:0] lead,
                                    input logic [7:0] c1);
    logic r;
    case (len)
      LEN_W'(2): r = (lead[4:1] == 4'd0);
      LEN_W'(3): r = (lead[3:0] == 4'd0) && !c1[5];
      LEN_W'(4): r = (lead[2:0] == 3'd0) && (c1[5:4] == 2'd0);
      LEN_W'(5): r = (lead[1:0] == 2'd0) && (c1[5:3] == 3'd0);
      LEN_W'(6): r = !lead[0] && (c1[5:2] == 4'd0);
      default:   r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/utf8v_dp.sv */
`default_nettype none

module utf8v_dp
  import utf8v_pkg::*;
#(
  parameter int MAX_SEQUENCE = MAX_SEQUENCE_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire in_t        in_data,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire dp_cmd_t    cmd,
  output dp_status_t      status,
  output out_t            out_data,
  output logic            out_valid,
  input  wire logic       out_stall
);

  localparam int CW = $clog2(MAX_SEQUENCE + 1);

  logic [7:0]       held_r [MAX_SEQUENCE];
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [LEN_W-1:0] pass_r, pass_nxt;
  logic [7:0]       byte_r;
  logic             last_r, zero_r;
  logic             err_r, err_nxt;
  logic             abort_r, abort_nxt;
  logic             term_r, term_nxt;
  logic [7:0]       replace_r;
  out_t             out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] cnt_ext;
  logic             cont_bad;
  logic             complete;
  logic             out_free;
  front_kind_t      kind;

  assign cnt_ext  = LEN_W'(cnt_r);
  assign len      = lead_length(held_r[0], LEN_W'(MAX_SEQUENCE));
  assign complete = (cnt_ext >= len);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cont_bad = 1'b0;
    for (int i = 1; i < MAX_SEQUENCE; i++) begin
      if ((LEN_W'(i) < cnt_ext) && (LEN_W'(i) < len) && (held_r[i][7:6] != CONT_TAG))
        cont_bad = 1'b1;
    end
  end

  always_comb begin
    if (cnt_r == '0) kind = K_EMPTY;
    else if (len == LEN_W'(1)) kind = K_SINGLE;
    else if (len == LEN_W'(0) || cont_bad) kind = K_BAD;
    else if (!complete) kind = (last_r || zero_r) ? K_BAD : K_WAIT;
    else if (overlong(len, held_r[0], held_r[1])) kind = K_BAD;
    else kind = K_GOOD;
  end

  always_comb begin
    status.kind         = kind;
    status.out_free     = out_free;
    status.replace_zero = (replace_r == 8'd0);
    status.last_one     = (cnt_r == CW'(1));
    status.pass_one     = (pass_r == LEN_W'(1));
    status.zero_r       = zero_r;
    status.last_r       = last_r;
    status.aborted      = abort_r;
    status.terminated   = term_r;
    status.in_zero_now  = (in_data.in_byte == 8'd0);
    status.in_last_now  = in_data.in_last;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.end_str) cnt_nxt = '0;
    else if (cmd.append) cnt_nxt = cnt_r + CW'(1);
    else if (cmd.shift) cnt_nxt = cnt_r - CW'(1);

    pass_nxt = pass_r;
    if (cmd.pass_load_len) pass_nxt = len - LEN_W'(1);
    else if (cmd.pass_load_cnt) pass_nxt = cnt_ext - LEN_W'(1);
    else if (cmd.pass_dec) pass_nxt = pass_r - LEN_W'(1);

    err_nxt   = cmd.end_str ? 1'b0 : (err_r || cmd.set_err);
    abort_nxt = cmd.end_str ? 1'b0 : (abort_r || cmd.set_abort);
    term_nxt  = cmd.end_str ? cmd.set_term : term_r;
  end

  always_comb begin
    out_nxt = out_r;
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_nxt.out_bad = cmd.bad;
      case (cmd.sel)
        SEL_FRONT: begin
          out_nxt.out_byte = held_r[0];
          out_nxt.out_last = last_r && !zero_r && (cnt_r == CW'(1));
        end
        SEL_REPLACE: begin
          out_nxt.out_byte = replace_r;
          out_nxt.out_last = last_r && !zero_r && (cnt_r == CW'(1));
        end
        SEL_LATCH: begin
          out_nxt.out_byte = byte_r;
          out_nxt.out_last = zero_r || last_r;
        end
        default: begin
          out_nxt.out_byte = byte_r;
          out_nxt.out_last = 1'b0;
        end
      endcase
      out_nxt.string_valid = out_nxt.out_last && !(err_r || cmd.bad);
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int i = 0; i < MAX_SEQUENCE - 1; i++) held_r[i] <= held_r[i+1];
    end else if (cmd.append) begin
      for (int i = 0; i < MAX_SEQUENCE; i++) begin
        if (cnt_r == CW'(i)) held_r[i] <= in_data.in_byte;
      end
    end
    if (cmd.latch) byte_r <= in_data.in_byte;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pass_r      <= '0;
      last_r      <= 1'b0;
      zero_r      <= 1'b0;
      err_r       <= 1'b0;
      abort_r     <= 1'b0;
      term_r      <= 1'b0;
      replace_r   <= REPLACE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      pass_r      <= pass_nxt;
      err_r       <= err_nxt;
      abort_r     <= abort_nxt;
      term_r      <= term_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.latch) begin
        last_r <= in_data.in_last;
        zero_r <= (in_data.in_byte == 8'd0);
      end
      if (cfg_wr_en) replace_r <= cfg_wr_data;
    end
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_SEQUENCE))
    else $error("held count beyond sequence limit");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |-> (cnt_r < CW'(MAX_SEQUENCE)))
    else $error("append into full hold buffer");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("emit over an untaken transaction");

  a_term_empty: assert property (@(posedge clk) disable iff (!rst_n)
    term_r |-> (cnt_r == '0))
    else $error("bytes held after terminator");

endmodule

`default_nettype wire

/* rtl/core/utf8v_ctrl.sv */
`default_nettype none

module utf8v_ctrl
  import utf8v_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_RESOLVE = 4'b0010,
    ST_PASS    = 4'b0100,
    ST_ECHO    = 4'b1000
  } state_t;

  state_t st_r, st_nxt;

  always_comb begin
    cmd = '0;
    cmd.sel = SEL_FRONT;
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (status.terminated) begin
            cmd.end_str = status.in_last_now;
          end else begin
            cmd.latch = 1'b1;
            if (status.in_zero_now) begin
              st_nxt = ST_RESOLVE;
            end else if (status.aborted) begin
              st_nxt = ST_ECHO;
            end else begin
              cmd.append = 1'b1;
              st_nxt = ST_RESOLVE;
            end
          end
        end
      end
      ST_RESOLVE: begin
        if (status.out_free) begin
          case (status.kind)
            K_EMPTY: begin
              if (status.zero_r) begin
                st_nxt = ST_ECHO;
              end else begin
                cmd.end_str = status.last_r;
                st_nxt = ST_IDLE;
              end
            end
            K_SINGLE: begin
              cmd.emit  = 1'b1;
              cmd.shift = 1'b1;
            end
            K_WAIT: begin
              st_nxt = ST_IDLE;
            end
            K_BAD: begin
              cmd.set_err = 1'b1;
              cmd.emit    = 1'b1;
              cmd.bad     = 1'b1;
              cmd.shift   = 1'b1;
              if (status.replace_zero) begin
                cmd.set_abort     = 1'b1;
                cmd.pass_load_cnt = 1'b1;
                if (!status.last_one) st_nxt = ST_PASS;
              end else begin
                cmd.sel = SEL_REPLACE;
              end
            end
            K_GOOD: begin
              cmd.emit          = 1'b1;
              cmd.shift         = 1'b1;
              cmd.pass_load_len = 1'b1;
              st_nxt            = ST_PASS;
            end
            default: st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PASS: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.shift    = 1'b1;
          cmd.pass_dec = 1'b1;
          if (status.pass_one) st_nxt = ST_RESOLVE;
        end
      end
      ST_ECHO: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.sel      = SEL_LATCH;
          cmd.end_str  = status.zero_r || status.last_r;
          cmd.set_term = status.zero_r && !status.last_r;
          st_nxt       = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign in_stall = (st_r != ST_IDLE);

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.latch || cmd.append) |-> (st_r == ST_IDLE))
    else $error("transaction taken outside idle");

  a_pass_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_PASS && status.out_free) |-> (cmd.emit && cmd.shift))
    else $error("pass state stalled with free output");

endmodule

`default_nettype wire

/* rtl/core/utf8_sequence_validator_core.sv */
// Results are registered in the output register before they leave the core.
// Throughput: one result per cycle while a sequence drains from the hold buffer and the
// output is not stalled; a single-byte character takes three steps (accept, emit, empty check).
// Input is taken only while the controller is idle; the output register decouples stalls.
// Reset: rst_n synchronous active low; clears control state, replace byte returns to 0x3F.
`default_nettype none

module utf8_sequence_validator_core
  import utf8v_pkg::*;
#(
  parameter int MAX_SEQUENCE = MAX_SEQUENCE_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire in_t        in_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  output out_t            out_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  utf8v_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  utf8v_dp #(
    .MAX_SEQUENCE (MAX_SEQUENCE)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .out_data    (out_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall)
  );

endmodule

`default_nettype wire
